// ----- hw/rtl/svct_pkg.sv -----
// ----------------------------------------------------------------------------
// svct_pkg
// Shared types and constants for the supervisor-call trap entry block.
// ----------------------------------------------------------------------------
package svct_pkg;

  // word memory geometry
  localparam int MEM_WORDS = 32768;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  // register file
  localparam int NUM_REGS = 9;
  localparam logic [3:0] REG_R1 = 4'd1;
  localparam logic [3:0] REG_R5 = 4'd5;
  localparam logic [3:0] REG_SP = 4'd6;
  localparam logic [3:0] REG_PC = 4'd7;
  localparam logic [3:0] REG_PS = 4'd8;

  // operation codes
  localparam logic [2:0] OP_MEM_WR = 3'd0;
  localparam logic [2:0] OP_MEM_RD = 3'd1;
  localparam logic [2:0] OP_REG_WR = 3'd2;
  localparam logic [2:0] OP_REG_RD = 3'd3;
  localparam logic [2:0] OP_EXEC   = 3'd4;

  // call classes
  localparam logic [1:0] CLS_INVALID = 2'd0;
  localparam logic [1:0] CLS_SVCA    = 2'd1;
  localparam logic [1:0] CLS_SVCB    = 2'd2;
  localparam logic [1:0] CLS_SVCC    = 2'd3;

  // vector addresses
  localparam logic [15:0] VEC_SVCA_TABLE = 16'h0022;
  localparam logic [15:0] VEC_SVCB       = 16'h0024;
  localparam logic [15:0] VEC_SVCC       = 16'h0026;

  // push sequence slots
  localparam logic [3:0] PUSH_PS     = 4'd0;
  localparam logic [3:0] PUSH_PC     = 4'd1;
  localparam logic [3:0] PUSH_OLD_SP = 4'd2;
  localparam logic [3:0] PUSH_LAST   = 4'd8;

  // stack step (minus two)
  localparam logic [15:0] STACK_STEP = 16'hFFFE;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] address;
    logic [15:0] data;
    logic [3:0]  reg_index;
    logic [7:0]  instruction;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] pc_out;
    logic [15:0] sp_out;
    logic [15:0] r1_out;
    logic [15:0] r5_out;
    logic        invalid;
  } result_t;

  // request from the sequencer to the word memory
  typedef struct packed {
    logic        we;
    logic [15:0] addr;
    logic [15:0] wdata;
  } mem_req_t;

endpackage

// ----- hw/rtl/svct_mem.sv -----
// ----------------------------------------------------------------------------
// svct_mem
// Single-port word memory with registered read; byte addresses, bit 0
// ignored, words beyond the memory drop writes and read as zero.
// ----------------------------------------------------------------------------
module svct_mem (
  input  logic               clk,
  input  svct_pkg::mem_req_t req,
  output logic [15:0]        rdata
);
  import svct_pkg::*;

  logic [15:0]       mem [MEM_WORDS];
  logic [MEM_AW-1:0] idx;
  logic              in_range;
  logic [15:0]       dout;
  logic              hit;

  // word index and range check
  assign idx      = req.addr[MEM_AW:1];
  assign in_range = ({1'b0, req.addr[15:1]} < 16'(MEM_WORDS));

  // one access a cycle
  always_ff @(posedge clk) begin
    if (req.we && in_range) begin
      mem[idx] <= req.wdata;
    end
    dout <= mem[idx];
    hit  <= in_range;
  end

  assign rdata = hit ? dout : 16'h0000;

endmodule

// ----- hw/rtl/supervisor_call_trap_entry.sv -----
// ----------------------------------------------------------------------------
// supervisor_call_trap_entry
// Executes the three supervisor-call instructions against an internal word
// memory and register file, and gives load/read access to both.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+----------------------
//   item     | in        | item_valid / item_stall    | item_t (op ... instr)
//   result   | out       | result_valid / result_stall| result_t
//
// SVCB/SVCC make nine stack pushes and a vector read through the one memory
// port; SVCA makes two pushes, a table-base read and a table read. All stack,
// table and PC sums go through a single shared 16-bit adder.
// Reset (rst, synchronous) clears the register file and the sequencer; the
// word memory is undefined until written. A stalled result holds; the next
// word is taken while it waits, and its result waits until the first leaves.
// ----------------------------------------------------------------------------
module supervisor_call_trap_entry (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  svct_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output svct_pkg::result_t result
);
  import svct_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEMWR,
    S_MEMRD,
    S_MEMRDW,
    S_REG,
    S_PUSH,
    S_VEC,
    S_ADD1,
    S_TAB,
    S_ADD2,
    S_LDPC,
    S_DONE
  } state_t;

  state_t      state;
  item_t       cur;
  logic [15:0] rf [NUM_REGS];
  logic [3:0]  cnt;
  logic [15:0] old_sp;
  logic [15:0] pc_slot;
  logic [15:0] pc_tmp;
  logic [15:0] rd;
  logic        inv;

  logic [1:0]  cls;
  logic [15:0] arg2;
  logic [3:0]  rf_idx;
  logic [15:0] rf_rd;
  logic [15:0] push_val;
  logic [15:0] add_a;
  logic [15:0] add_b;
  logic [15:0] sum;
  mem_req_t    mem_req;
  logic [15:0] mem_rdata;
  logic        reg_ok;

  assign cls    = cur.instruction[7:6];
  assign arg2   = {9'b0, cur.instruction[5:0], 1'b0};
  assign reg_ok = (cur.reg_index < 4'(NUM_REGS));

  assign item_stall = (state != S_IDLE);

  // register file read port, one signal-chosen index
  always_comb begin
    if (state == S_PUSH) begin
      if (cnt == PUSH_PS) begin
        rf_idx = REG_PS;
      end else if (cnt == PUSH_PC) begin
        rf_idx = REG_PC;
      end else begin
        rf_idx = 4'(PUSH_LAST - cnt);
      end
    end else begin
      rf_idx = cur.reg_index;
    end
  end

  assign rf_rd    = (rf_idx < 4'(NUM_REGS)) ? rf[rf_idx] : 16'h0000;
  assign push_val = (cnt == PUSH_OLD_SP) ? old_sp : rf_rd;

  // shared adder operands
  always_comb begin
    case (state)
      S_ADD1: begin
        add_a = mem_rdata;
        add_b = arg2;
      end
      S_ADD2: begin
        add_a = pc_tmp;
        add_b = mem_rdata;
      end
      default: begin
        add_a = rf[REG_SP];
        add_b = STACK_STEP;
      end
    endcase
  end

  assign sum = add_a + add_b;

  // memory request
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.addr  = cur.address;
    mem_req.wdata = cur.data;
    case (state)
      S_MEMWR: begin
        mem_req.we = 1'b1;
      end
      S_PUSH: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = sum;
        mem_req.wdata = push_val;
      end
      S_VEC: begin
        if (cls == CLS_SVCA) begin
          mem_req.addr = VEC_SVCA_TABLE;
        end else if (cls == CLS_SVCB) begin
          mem_req.addr = VEC_SVCB;
        end else begin
          mem_req.addr = VEC_SVCC;
        end
      end
      S_TAB: begin
        mem_req.addr = pc_tmp;
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  svct_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // sequencer, register file and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      cnt          <= '0;
      for (int i = 0; i < NUM_REGS; i++) begin
        rf[i] <= 16'h0000;
      end
    end else begin
      // the finishing step owns result_valid while it is active
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur <= item;
            rd  <= 16'h0000;
            inv <= 1'b0;
            cnt <= '0;
            case (item.op)
              OP_MEM_WR: state <= S_MEMWR;
              OP_MEM_RD: state <= S_MEMRD;
              OP_REG_WR: state <= S_REG;
              OP_REG_RD: state <= S_REG;
              OP_EXEC: begin
                if (item.instruction[7:6] == CLS_INVALID) begin
                  inv   <= 1'b1;
                  state <= S_DONE;
                end else begin
                  old_sp <= rf[REG_SP];
                  state  <= S_PUSH;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_MEMWR: state <= S_DONE;
        S_MEMRD: state <= S_MEMRDW;
        S_MEMRDW: begin
          rd    <= mem_rdata;
          state <= S_DONE;
        end
        S_REG: begin
          if (reg_ok && cur.op == OP_REG_WR) begin
            rf[cur.reg_index] <= cur.data;
          end else if (cur.op == OP_REG_RD) begin
            rd <= rf_rd;
          end
          state <= S_DONE;
        end
        S_PUSH: begin
          rf[REG_SP] <= sum;
          if (cnt == PUSH_PC) begin
            pc_slot <= sum;
          end
          if ((cls == CLS_SVCA && cnt == PUSH_PC) || cnt == PUSH_LAST) begin
            state <= S_VEC;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_VEC: begin
          if (cls == CLS_SVCA) begin
            state <= S_ADD1;
          end else begin
            rf[REG_R1] <= pc_slot;
            rf[REG_R5] <= arg2;
            state      <= S_LDPC;
          end
        end
        S_ADD1: begin
          pc_tmp <= sum;
          state  <= S_TAB;
        end
        S_TAB: state <= S_ADD2;
        S_ADD2: begin
          rf[REG_PC] <= sum;
          state      <= S_DONE;
        end
        S_LDPC: begin
          rf[REG_PC] <= mem_rdata;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid     <= 1'b1;
            result.read_data <= rd;
            result.pc_out    <= rf[REG_PC];
            result.sp_out    <= rf[REG_SP];
            result.r1_out    <= rf[REG_R1];
            result.r5_out    <= rf[REG_R5];
            result.invalid   <= inv;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result appears only out of the finishing step
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside finishing step");

  // push counter stays within the nine-word frame
  a_push_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_PUSH |-> cnt <= PUSH_LAST)
    else $error("push counter beyond frame");

  // every push lowers the stack pointer by one word
  a_push_sp: assert property (@(posedge clk) disable iff (rst)
    state == S_PUSH |=> rf[REG_SP] == 16'($past(rf[REG_SP]) + STACK_STEP))
    else $error("stack pointer step wrong");

  // class zero goes straight to finish, flagged
  a_class_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && item_valid && item.op == OP_EXEC &&
     item.instruction[7:6] == CLS_INVALID) |=> (state == S_DONE && inv))
    else $error("class zero not flagged");

endmodule

// ----- tb/supervisor_call_trap_entry_test.sv -----
// ----------------------------------------------------------------------------
// supervisor_call_trap_entry_test
// Self-checking bench for the supervisor-call trap entry block. Memory,
// register and call words go in as random bursts. Results are taken under a
// stall pattern that keeps changing. Each result is compared, field by field,
// with a word-level model of the memory, the register file and the three
// call sequences that the bench keeps up to date.
// ----------------------------------------------------------------------------
module supervisor_call_trap_entry_test;
  import svct_pkg::*;

  localparam int RANDOM_WORDS = 1500;
  localparam int DRAIN_CYCLES = 40;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BLOCK} stall_mode_t;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  // cpu state model and the queue of cpu views still owed by the block
  class trap_entry_check;
    logic [15:0] mem [MEM_WORDS];
    bit          written [MEM_WORDS];
    int unsigned written_list [$];
    logic [15:0] regs [NUM_REGS];
    result_t     views_due [$];
    int          faults;
    int          checked;
    int          calls [4];

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (calls[i]) calls[i] = 0;
      faults  = 0;
      checked = 0;
    endfunction

    function void mem_write(logic [15:0] a, logic [15:0] d);
      if (a[15:1] < MEM_WORDS) begin
        mem[a[15:1]] = d;
        if (!written[a[15:1]]) begin
          written[a[15:1]] = 1'b1;
          written_list.push_back(a[15:1]);
        end
      end
    endfunction

    function logic [15:0] mem_read(logic [15:0] a);
      if (a[15:1] < MEM_WORDS) return mem[a[15:1]];
      return '0;
    endfunction

    function void push_word(logic [15:0] d);
      regs[REG_SP] = regs[REG_SP] - 16'd2;
      mem_write(regs[REG_SP], d);
    endfunction

    // the call sequences; returns the invalid flag
    function bit enter_call(logic [7:0] ins);
      logic [1:0]  cls;
      logic [15:0] arg2;
      logic [15:0] old_sp;
      logic [15:0] slot;
      logic [15:0] pc;
      int          r;
      cls  = ins[7:6];
      arg2 = {9'd0, ins[5:0], 1'b0};
      if (cls == CLS_INVALID) return 1'b1;
      old_sp = regs[REG_SP];
      push_word(regs[REG_PS]);
      push_word(regs[REG_PC]);
      if (cls == CLS_SVCA) begin
        pc = mem_read(VEC_SVCA_TABLE) + arg2;
        regs[REG_PC] = pc + mem_read(pc);
      end else begin
        slot = regs[REG_SP];
        push_word(old_sp);
        for (r = 5; r >= 0; r--) push_word(regs[r]);
        regs[REG_R1] = slot;
        regs[REG_R5] = arg2;
        regs[REG_PC] = mem_read(cls == CLS_SVCB ? VEC_SVCB : VEC_SVCC);
      end
      return 1'b0;
    endfunction

    // an accepted word: advance the state and queue the view it leaves
    function void note_word(item_t w);
      result_t v;
      v = '0;
      case (w.op)
        OP_MEM_WR: mem_write(w.address, w.data);
        OP_MEM_RD: v.read_data = mem_read(w.address);
        OP_REG_WR: if (w.reg_index < NUM_REGS) regs[w.reg_index] = w.data;
        OP_REG_RD: if (w.reg_index < NUM_REGS) v.read_data = regs[w.reg_index];
        OP_EXEC: begin
          v.invalid = enter_call(w.instruction);
          calls[w.instruction[7:6]]++;
        end
        default: ;
      endcase
      v.pc_out = regs[REG_PC];
      v.sp_out = regs[REG_SP];
      v.r1_out = regs[REG_R1];
      v.r5_out = regs[REG_R5];
      views_due.push_back(v);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", field, want, got);
        faults++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (views_due.size() == 0) begin
        $error("result word with nothing due: %h", got);
        faults++;
        return;
      end
      want = views_due.pop_front();
      checked++;
      compare("read_data", want.read_data, got.read_data);
      compare("pc_out", want.pc_out, got.pc_out);
      compare("sp_out", want.sp_out, got.sp_out);
      compare("r1_out", want.r1_out, got.r1_out);
      compare("r5_out", want.r5_out, got.r5_out);
      compare("invalid", 16'(want.invalid), 16'(got.invalid));
    endfunction

    // true when one of the first n pushes from sp lands on the word of a
    function bit pushed_to(logic [15:0] a, logic [15:0] sp, int n);
      logic [15:0] s;
      int          k;
      for (k = 1; k <= n; k++) begin
        s = sp - 16'(2 * k);
        if (s[15:1] == a[15:1]) return 1'b1;
      end
      return 1'b0;
    endfunction

    // first word a call would read before anything wrote it, or -1
    function int undefined_read(logic [7:0] ins);
      logic [1:0]  cls;
      logic [15:0] sp;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] base;
      cls = ins[7:6];
      sp  = regs[REG_SP];
      if (cls == CLS_INVALID) return -1;
      if (cls != CLS_SVCA) begin
        base = (cls == CLS_SVCB) ? VEC_SVCB : VEC_SVCC;
        if (written[base[15:1]] || pushed_to(base, sp, int'(PUSH_LAST) + 1)) return -1;
        return int'(base[15:1]);
      end
      if (!written[VEC_SVCA_TABLE[15:1]] &&
          !pushed_to(VEC_SVCA_TABLE, sp, int'(PUSH_PC) + 1))
        return int'(VEC_SVCA_TABLE[15:1]);
      // table base as it stands after the two pushes
      p1 = sp - 16'd2;
      p2 = sp - 16'd4;
      if (VEC_SVCA_TABLE[15:1] == p2[15:1]) base = regs[REG_PC];
      else if (VEC_SVCA_TABLE[15:1] == p1[15:1]) base = regs[REG_PS];
      else base = mem[VEC_SVCA_TABLE[15:1]];
      base = base + {9'd0, ins[5:0], 1'b0};
      if (!written[base[15:1]] && !pushed_to(base, sp, int'(PUSH_PC) + 1))
        return int'(base[15:1]);
      return -1;
    endfunction
  endclass

  trap_entry_check chk = new();
  int              burst_left = 0;

  supervisor_call_trap_entry i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // clock
  initial forever #5 clk = ~clk;

  // overall limit
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic item_t noise_word();
    item_t w;
    w.op          = 3'($urandom_range(0, 7));
    w.address     = 16'($urandom);
    w.data        = 16'($urandom);
    w.reg_index   = 4'($urandom_range(0, 15));
    w.instruction = 8'($urandom);
    return w;
  endfunction

  // one word through the input handshake, then the burst gap if one is due
  task automatic send_word(item_t w);
    int gap;
    item_valid <= 1'b1;
    item       <= w;
    do @(negedge clk); while (item_stall);
    chk.note_word(w);
    @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_op(logic [2:0] op, logic [15:0] address, logic [15:0] data,
                         logic [3:0] reg_index);
    item_t w;
    w           = noise_word();
    w.op        = op;
    w.address   = address;
    w.data      = data;
    w.reg_index = reg_index;
    send_word(w);
  endtask

  // call word, preceded by writes to any word it would read undefined
  task automatic run_call(logic [7:0] ins);
    item_t w;
    int    m;
    m = chk.undefined_read(ins);
    while (m >= 0) begin
      w         = noise_word();
      w.op      = OP_MEM_WR;
      w.address = {m[14:0], 1'($urandom_range(0, 1))};
      send_word(w);
      m = chk.undefined_read(ins);
    end
    w             = noise_word();
    w.op          = OP_EXEC;
    w.instruction = ins;
    send_word(w);
  endtask

  // result stall pattern, changing mode after each random span
  initial begin : result_stall_pattern
    stall_mode_t mode;
    int          span;
    int          c;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(4, 48);
      for (c = 0; c < span; c++) begin
        @(posedge clk);
        case (mode)
          STALL_NONE:  result_stall <= 1'b0;
          STALL_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: result_stall <= ($urandom_range(0, 1) == 0);
          default:     result_stall <= (c < span / 2);
        endcase
      end
    end
  end

  // result sampling; a word seen here is taken at the next rising edge
  initial begin : result_monitor
    forever begin
      @(negedge clk);
      if (!rst && result_valid && !result_stall) chk.check_word(result);
    end
  end

  initial begin : stimulus
    item_t      w;
    int         counted;
    int         pick;
    int         idx;
    int         drain;
    int         k;
    logic [1:0] cls;
    counted = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: address extremes, register edges, spare ops, every call class
    send_op(OP_MEM_WR, 16'h0000, 16'hFFFF, REG_PS);
    send_op(OP_MEM_WR, 16'hFFFF, 16'h0000, REG_PS);
    send_op(OP_MEM_RD, 16'hFFFE, 16'h0000, REG_PS);
    send_op(OP_MEM_RD, 16'h0001, 16'hFFFF, REG_PS);
    send_op(OP_REG_WR, 16'h0000, 16'hFFFF, REG_PS);
    send_op(OP_REG_WR, 16'h0000, 16'h1234, REG_PC);
    send_op(OP_REG_WR, 16'h0000, 16'h0000, REG_SP);
    send_op(OP_REG_WR, 16'h0000, 16'hBEEF, 4'hF);
    send_op(OP_REG_RD, 16'h0000, 16'h0000, 4'(NUM_REGS));
    send_op(OP_REG_RD, 16'h0000, 16'h0000, REG_PS);
    for (k = 1; k <= 3; k++) send_op(3'(OP_EXEC + k), 16'hFFFF, 16'hFFFF, 4'hF);
    run_call({CLS_INVALID, 6'h3F});
    // stack below zero wraps to the top of memory
    run_call({CLS_SVCA, 6'h00});
    run_call({CLS_SVCA, 6'h3F});
    run_call({CLS_SVCB, 6'h00});
    run_call({CLS_SVCC, 6'h3F});
    // pushes that land on the vectors are seen by the vector read
    send_op(OP_REG_WR, 16'h0000, 16'h0028, REG_SP);
    run_call({CLS_SVCB, 6'h15});
    send_op(OP_REG_WR, 16'h0000, 16'h0026, REG_SP);
    run_call({CLS_SVCA, 6'h2A});
    send_op(OP_MEM_RD, 16'h0022, 16'h0000, REG_SP);
    send_op(OP_REG_RD, 16'h0000, 16'h0000, REG_SP);

    // random mix, mostly register set-up and calls
    while (counted < RANDOM_WORDS) begin
      w    = noise_word();
      pick = $urandom_range(0, 99);
      if (pick < 18) begin
        w.op = OP_MEM_WR;
        if ($urandom_range(0, 3) == 0) w.address = 16'($urandom_range(16'h0020, 16'h0027));
        send_word(w);
        counted++;
      end else if (pick < 32) begin
        if (chk.written_list.size() != 0) begin
          idx       = chk.written_list[$urandom_range(0, chk.written_list.size() - 1)];
          w.op      = OP_MEM_RD;
          w.address = {idx[14:0], 1'($urandom_range(0, 1))};
          send_word(w);
          counted++;
        end
      end else if (pick < 60) begin
        w.op = (pick < 50) ? OP_REG_WR : OP_REG_RD;
        if ($urandom_range(0, 9) == 0) w.reg_index = 4'($urandom_range(NUM_REGS, 15));
        else w.reg_index = 4'($urandom_range(0, NUM_REGS - 1));
        // keep the stack near the vectors or the wrap point now and then
        if (w.reg_index == REG_SP) begin
          case ($urandom_range(0, 3))
            0: w.data = 16'($urandom_range(0, 16'h0040));
            1: w.data = 16'($urandom_range(16'hFFC0, 16'hFFFF));
            default: ;
          endcase
        end
        send_word(w);
        if (w.reg_index < NUM_REGS) counted++;
      end else if (pick < 95) begin
        cls = ($urandom_range(0, 11) == 0) ? CLS_INVALID
                                           : 2'($urandom_range(CLS_SVCA, CLS_SVCC));
        run_call({cls, w.instruction[5:0]});
        counted++;
      end else begin
        w.op = 3'($urandom_range(OP_EXEC + 1, 7));
        send_word(w);
      end
    end
    item_valid <= 1'b0;

    // drain outstanding results, then watch for strays
    drain = 0;
    while (chk.views_due.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.views_due.size() != 0) begin
      $error("%0d results never arrived", chk.views_due.size());
      chk.faults++;
    end
    $display("Checked %0d results from memory, register and call words", chk.checked);
    $display("Calls run: SVCA %0d, SVCB %0d, SVCC %0d, class zero %0d",
             chk.calls[CLS_SVCA], chk.calls[CLS_SVCB], chk.calls[CLS_SVCC],
             chk.calls[CLS_INVALID]);
    if (chk.faults == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/svct_pkg.sv
hw/rtl/svct_mem.sv
hw/rtl/supervisor_call_trap_entry.sv
tb/supervisor_call_trap_entry_test.sv
